[rtl/pcmfc_pkg.sv]
// Package for the PCM sample format converter: format codes and widths.
package pcmfc_pkg;

  localparam int unsigned RAW_W  = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FMT_W  = 4;

  typedef enum logic [FMT_W-1:0] {
    FMT_U8    = 4'd0,
    FMT_I8    = 4'd1,
    FMT_I16LE = 4'd2,
    FMT_I16BE = 4'd3,
    FMT_I24LE = 4'd4,
    FMT_I24BE = 4'd5,
    FMT_I32LE = 4'd6,
    FMT_I32BE = 4'd7,
    FMT_F32   = 4'd8,
    FMT_F64   = 4'd9
  } fmt_t;

  localparam logic [FMT_W-1:0] FMT_RESET = FMT_I16LE;

  localparam logic [WORD_W-1:0] SGL_INF  = 32'h7F80_0000;
  localparam logic [WORD_W-1:0] SGL_QNAN = 32'h7FC0_0000;

endpackage

[rtl/pcmfc_convert.sv]
// Combinational conversion of one raw sample to the internal sample word.
module pcmfc_convert (
  input  logic [pcmfc_pkg::FMT_W-1:0]  fmt,
  input  logic [pcmfc_pkg::RAW_W-1:0]  raw,
  output logic [pcmfc_pkg::WORD_W-1:0] word,
  output logic                         is_flt
);
  import pcmfc_pkg::*;

  // integer to single path
  logic [31:0] ival;
  logic        ineg;
  logic [31:0] imag;
  logic [4:0]  ipos;
  logic [31:0] inorm;
  logic        iinc;
  logic [24:0] iq;
  logic [7:0]  iexp;
  logic [31:0] isgl;
  logic        is24;

  // double to single path
  logic        dneg;
  logic [10:0] dex;
  logic [51:0] dman;
  logic [63:0] dm;
  logic        dinc;
  logic [24:0] dq;
  logic [32:0] dsum;
  logic [5:0]  dsh;
  logic [5:0]  dsh1;
  logic [63:0] dshr;
  logic        drb;
  logic        dst;
  logic [24:0] dsq;
  logic [31:0] dsgl;

  always_comb begin
    is24 = (fmt == FMT_I24LE) || (fmt == FMT_I24BE);
    case (fmt)
      FMT_I24LE: ival = {{8{raw[23]}}, raw[23:0]};
      FMT_I24BE: ival = {{8{raw[7]}}, raw[7:0], raw[15:8], raw[23:16]};
      FMT_I32BE: ival = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      default:   ival = raw[31:0];
    endcase
    ineg = ival[31];
    imag = ineg ? (~ival + 32'd1) : ival;
    ipos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (imag[i]) ipos = 5'(i);
    end
    inorm = imag << (5'd31 - ipos);
    iinc  = inorm[7] & ((|inorm[6:0]) | inorm[8]);
    iq    = {1'b0, inorm[31:8]} + {24'd0, iinc};
    iexp  = {3'd0, ipos} + (is24 ? 8'd103 : 8'd95);
    isgl  = {ineg, 31'd0} | ({iexp, 24'd0} >> 1) + {7'd0, iq};
    if (imag == 32'd0) isgl = 32'd0;
  end

  always_comb begin
    dneg = raw[63];
    dex  = raw[62:52];
    dman = raw[51:0];
    dm   = {11'd0, 1'b1, dman};
    dsh  = 6'd0;
    dsh1 = 6'd0;
    dshr = 64'd0;
    drb  = 1'b0;
    dst  = 1'b0;
    dsq  = 25'd0;
    dinc = dm[28] & ((|dm[27:0]) | dm[29]);
    dq   = {1'b0, dm[52:29]} + {24'd0, dinc};
    dsum = {2'd0, 8'(dex - 11'd897), 23'd0} + {8'd0, dq};
    if (dex == 11'h7FF) begin
      if (dman == 52'd0) dsgl = {dneg, 31'd0} | SGL_INF;
      else dsgl = {dneg, 31'd0} | SGL_QNAN | {9'd0, dman[51:29]};
    end else if (dex >= 11'd1151) begin
      dsgl = {dneg, 31'd0} | SGL_INF;
    end else if (dex >= 11'd897) begin
      if (dsum >= {1'b0, SGL_INF}) dsgl = {dneg, 31'd0} | SGL_INF;
      else dsgl = {dneg, dsum[30:0]};
    end else if (dex >= 11'd863) begin
      // subnormal result: right shift of 30 to 63 with round and sticky
      dsh  = 6'(11'd926 - dex);
      dsh1 = dsh - 6'd1;
      dshr = dm >> dsh;
      drb  = dm[dsh1];
      dst  = |(dm & ((64'd1 << dsh1) - 64'd1));
      dsq  = {1'b0, dshr[23:0]} + {24'd0, drb & (dst | dshr[0])};
      dsgl = {dneg, 6'd0, dsq};
    end else begin
      dsgl = {dneg, 31'd0};
    end
  end

  always_comb begin
    is_flt = 1'b1;
    case (fmt)
      FMT_U8:    begin word = {16'd0, raw[7] ^ 1'b1, raw[6:0], 8'd0}; is_flt = 1'b0; end
      FMT_I8:    begin word = {16'd0, raw[7:0], 8'd0}; is_flt = 1'b0; end
      FMT_I16LE: begin word = {16'd0, raw[15:0]}; is_flt = 1'b0; end
      FMT_I16BE: begin word = {16'd0, raw[7:0], raw[15:8]}; is_flt = 1'b0; end
      FMT_I24LE, FMT_I24BE, FMT_I32LE, FMT_I32BE: word = isgl;
      FMT_F32:   word = raw[31:0];
      FMT_F64:   word = dsgl;
      default:   begin word = 32'd0; is_flt = 1'b0; end
    endcase
  end

endmodule

[rtl/pcm_sample_format_converter.sv]
// Top level of the PCM sample format converter: input and result registers.
// Converts one raw sample per transfer into a 16-bit integer or an IEEE single,
// as chosen by the format register (reset: 16-bit little-endian). One sample
// is taken every cycle while in_tready is high. A sample goes into the input
// register at its input transfer; its conversion is loaded into the result
// register once that register is empty or its sample leaves, and is offered
// from there. While out_tready is low, in_tready drops once both registers
// hold samples. Write the format only while no samples are in flight.
module pcm_sample_format_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pcmfc_pkg::FMT_W-1:0]   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pcmfc_pkg::RAW_W-1:0]   in_tdata,   // raw_sample
  input  logic                          in_tlast,   // last_sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pcmfc_pkg::WORD_W-1:0]  out_tdata,  // sample_word
  output logic                          out_tuser,  // is_float
  output logic                          out_tlast   // last_out
);
  import pcmfc_pkg::*;

  logic [FMT_W-1:0]  fmt_r;
  logic              s1_valid_r;
  logic [RAW_W-1:0]  s1_raw_r;
  logic              s1_last_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_flt_r;
  logic              out_last_r;
  logic              adv;
  logic [WORD_W-1:0] cv_word;
  logic              cv_flt;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;

  pcmfc_convert u_conv (
    .fmt    (fmt_r),
    .raw    (s1_raw_r),
    .word   (cv_word),
    .is_flt (cv_flt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= cfg_wdata;
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_raw_r  <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv && s1_valid_r) begin
      out_word_r <= cv_word;
      out_flt_r  <= cv_flt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_flt_r;
  assign out_tlast  = out_last_r;

endmodule
